[hdl/note_tone_generator_top_macros.svh]
// Assertion macros for the note tone generator top level.
// Expects clk_i and rst_ni in the scope of use.
`ifndef NOTE_TONE_GENERATOR_TOP_MACROS_SVH
`define NOTE_TONE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ntg_pkg.sv]
// Shared types, constants and the sine table of the note tone generator.
// No dependencies.
package ntg_pkg;

  localparam int CLK_W       = 24;
  localparam int FREQ_W      = 16;
  localparam int DUR_W       = 16;
  localparam int TPM_W       = 16;
  localparam int GAP_W       = 10;
  localparam int SAMPLE_W    = 8;
  localparam int SINE_POINTS = 32;
  localparam int IDX_W       = $clog2(SINE_POINTS);
  localparam int IVL_W       = CLK_W - IDX_W;
  localparam int DIV_STEPS   = CLK_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = CLK_W;

  localparam int TIMER_BITS_DEF = 16;

  localparam logic [CLK_W-1:0] TONE_CLOCK_RST = CLK_W'(1000000);
  localparam logic [TPM_W-1:0] TICKS_PER_MS_RST = TPM_W'(1000);
  localparam logic [GAP_W-1:0] GAP_MS_RST = GAP_W'(25);

  localparam logic [CFG_IDX_W-1:0] REG_TONE_CLOCK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic MODE_PWM  = 1'b0;
  localparam logic MODE_SINE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE,
    PH_GAP
  } phase_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIV,
    CS_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic              cmd;
    logic [FREQ_W-1:0] frequency;
    logic [DUR_W-1:0]  note_ms;
  } in_item_t;

  typedef struct packed {
    logic                pwm_level;
    logic [SAMPLE_W-1:0] dac_sample;
    logic                busy_res;
    logic                accepted;
    logic                song_end;
  } out_item_t;

  typedef struct packed {
    logic [CLK_W-1:0] tone_clock_hz;
    logic [TPM_W-1:0] ticks_per_ms;
    logic [GAP_W-1:0] gap_ms;
    logic             output_mode;
  } cfg_t;

  typedef struct packed {
    logic hold;
    logic div_load;
    logic div_step;
    logic div_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_req;
  } dp_status_t;

  function automatic logic [SAMPLE_W-1:0] sine_lookup(input logic [IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] val;
    case (idx)
      5'd0:  val = 8'd128;
      5'd1:  val = 8'd153;
      5'd2:  val = 8'd177;
      5'd3:  val = 8'd199;
      5'd4:  val = 8'd219;
      5'd5:  val = 8'd234;
      5'd6:  val = 8'd246;
      5'd7:  val = 8'd253;
      5'd8:  val = 8'd255;
      5'd9:  val = 8'd253;
      5'd10: val = 8'd246;
      5'd11: val = 8'd234;
      5'd12: val = 8'd219;
      5'd13: val = 8'd199;
      5'd14: val = 8'd177;
      5'd15: val = 8'd153;
      5'd16: val = 8'd128;
      5'd17: val = 8'd103;
      5'd18: val = 8'd79;
      5'd19: val = 8'd57;
      5'd20: val = 8'd37;
      5'd21: val = 8'd22;
      5'd22: val = 8'd10;
      5'd23: val = 8'd3;
      5'd24: val = 8'd0;
      5'd25: val = 8'd3;
      5'd26: val = 8'd10;
      5'd27: val = 8'd22;
      5'd28: val = 8'd37;
      5'd29: val = 8'd57;
      5'd30: val = 8'd79;
      5'd31: val = 8'd103;
      default: val = 8'd128;
    endcase
    return val;
  endfunction

endpackage

[hdl/ntg_ctrl.sv]
// Sequencer for the note load division of the note tone generator.
// Depends on ntg_pkg.
module ntg_ctrl import ntg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_take_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic start;

  assign start = item_take_i & status_i.div_req;

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      CS_IDLE: begin
        if (start) state_d = CS_DIV;
      end
      CS_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = CS_COMMIT;
          step_d  = '0;
        end
      end
      CS_COMMIT: state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      CS_IDLE:   cmd_o.div_load = start;
      CS_DIV: begin
        cmd_o.hold     = 1'b1;
        cmd_o.div_step = 1'b1;
      end
      CS_COMMIT: begin
        cmd_o.hold       = 1'b1;
        cmd_o.div_commit = 1'b1;
      end
      default:   cmd_o.hold = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[hdl/ntg_datapath.sv]
// Tone timer, sine stepper, duration counters and serial divider.
// Depends on ntg_pkg.
module ntg_datapath import ntg_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_take_i,
  input  in_item_t   item_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output out_item_t  result_o
);

  localparam int WW = (TIMER_BITS > CLK_W) ? TIMER_BITS : CLK_W;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] reload_q, reload_d;
  logic [TIMER_BITS-1:0] cmp_q, cmp_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d;
  logic [IVL_W-1:0]      ivl_q, ivl_d;
  logic [IVL_W-1:0]      icnt_q, icnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TPM_W-1:0]      presc_q, presc_d;
  logic [DUR_W-1:0]      elapsed_q, elapsed_d;
  logic [DUR_W-1:0]      len_q, len_d;
  logic                  rest_q, rest_d;

  logic [FREQ_W-1:0]     rem_q;
  logic [CLK_W-1:0]      quo_q;
  logic [FREQ_W-1:0]     den_q;
  logic [FREQ_W:0]       rem_ext;
  logic                  rem_ge;
  logic [FREQ_W-1:0]     rem_next;

  logic [CLK_W-1:0]      q_m1;
  logic [WW-1:0]         q_w;
  logic [WW-1:0]         tmax_w;
  logic [TIMER_BITS-1:0] reload_sat;
  logic [IVL_W-1:0]      ivl_raw;

  logic                  tone;
  logic                  sine_on;
  logic [TPM_W-1:0]      tpm;
  logic [TPM_W-1:0]      presc_inc;
  logic [DUR_W-1:0]      el_new;
  logic [IVL_W-1:0]      icnt_inc;
  logic                  wrapped;
  logic                  to_gap;

  assign status_o.div_req = (item_i.cmd == CMD_LOAD) && (phase_q == PH_IDLE) &&
                            (item_i.note_ms != '0) && (item_i.frequency != '0);

  // Restoring divider, one quotient bit a step.
  assign rem_ext  = {rem_q, quo_q[CLK_W-1]};
  assign rem_ge   = rem_ext >= {1'b0, den_q};
  assign rem_next = rem_ge ? FREQ_W'(rem_ext - {1'b0, den_q}) : rem_ext[FREQ_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q <= cfg_i.tone_clock_hz;
      den_q <= item_i.frequency;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[CLK_W-2:0], rem_ge};
    end
  end

  // Period and sample interval from the finished quotient.
  assign q_m1       = (quo_q == '0) ? '0 : quo_q - CLK_W'(1);
  assign q_w        = WW'(q_m1);
  assign tmax_w     = WW'({TIMER_BITS{1'b1}});
  assign reload_sat = TIMER_BITS'((q_w > tmax_w) ? tmax_w : q_w);
  assign ivl_raw    = quo_q[CLK_W-1:IDX_W];

  assign tone      = (phase_q == PH_NOTE) && !rest_q;
  assign sine_on   = tone && (cfg_i.output_mode == MODE_SINE);
  assign tpm       = (cfg_i.ticks_per_ms == '0) ? TPM_W'(1) : cfg_i.ticks_per_ms;
  assign presc_inc = presc_q + TPM_W'(1);
  assign icnt_inc  = icnt_q + IVL_W'(1);

  always_comb begin
    phase_d   = phase_q;
    reload_d  = reload_q;
    cmp_d     = cmp_q;
    cnt_d     = cnt_q;
    ivl_d     = ivl_q;
    icnt_d    = icnt_q;
    idx_d     = idx_q;
    presc_d   = presc_q;
    elapsed_d = elapsed_q;
    len_d     = len_q;
    rest_d    = rest_q;
    el_new    = elapsed_q;
    wrapped   = 1'b0;
    to_gap    = 1'b0;
    result_o  = '0;

    if (item_take_i) begin
      if (item_i.cmd == CMD_LOAD) begin
        if (phase_q == PH_IDLE) begin
          result_o.accepted = 1'b1;
          if (item_i.note_ms == '0) begin
            result_o.song_end = 1'b1;
          end else begin
            len_d     = item_i.note_ms;
            elapsed_d = '0;
            presc_d   = '0;
            cnt_d     = '0;
            icnt_d    = '0;
            idx_d     = '0;
            phase_d   = PH_NOTE;
            rest_d    = (item_i.frequency == '0);
            if (item_i.frequency == '0) cmp_d = '0;
          end
        end
      end else begin
        result_o.pwm_level = tone && (cfg_i.output_mode == MODE_PWM) && (cnt_q < cmp_q);
        result_o.dac_sample = sine_on ? sine_lookup(idx_q) : '0;

        cnt_d = (cnt_q >= reload_q) ? '0 : cnt_q + TIMER_BITS'(1);

        // Millisecond prescaler, elapsed count saturates.
        if (phase_q != PH_IDLE) begin
          presc_d = presc_inc;
          if (presc_inc >= tpm) begin
            presc_d = '0;
            if (elapsed_q != '1) el_new = elapsed_q + DUR_W'(1);
          end
        end
        elapsed_d = el_new;

        if (sine_on) begin
          icnt_d = icnt_inc;
          if (icnt_inc >= ivl_q) begin
            icnt_d  = '0;
            idx_d   = idx_q + IDX_W'(1);
            wrapped = (idx_q == '1);
          end
        end

        if (phase_q == PH_NOTE) begin
          if (sine_on) to_gap = wrapped && (el_new >= len_q);
          else         to_gap = el_new >= len_q;
          if (to_gap) begin
            presc_d   = '0;
            elapsed_d = '0;
            phase_d   = (cfg_i.gap_ms == '0) ? PH_IDLE : PH_GAP;
          end
        end else if (phase_q == PH_GAP) begin
          if (el_new >= DUR_W'(cfg_i.gap_ms)) phase_d = PH_IDLE;
        end
      end
      result_o.busy_res = (phase_d != PH_IDLE);
    end

    if (cmd_i.div_commit) begin
      reload_d = reload_sat;
      cmp_d    = reload_sat >> 1;
      ivl_d    = (ivl_raw == '0) ? IVL_W'(1) : ivl_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      reload_q  <= '0;
      cmp_q     <= '0;
      cnt_q     <= '0;
      ivl_q     <= '0;
      icnt_q    <= '0;
      idx_q     <= '0;
      presc_q   <= '0;
      elapsed_q <= '0;
      len_q     <= '0;
      rest_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      reload_q  <= reload_d;
      cmp_q     <= cmp_d;
      cnt_q     <= cnt_d;
      ivl_q     <= ivl_d;
      icnt_q    <= icnt_d;
      idx_q     <= idx_d;
      presc_q   <= presc_d;
      elapsed_q <= elapsed_d;
      len_q     <= len_d;
      rest_q    <= rest_d;
    end
  end

endmodule

[hdl/note_tone_generator_top.sv]
// Note tone generator: square wave or sine sample player, one note at a time.
// Input channel (in_valid_i/in_stall_o, in_data_i) carries requests: a tick of
// the tone clock or a note load (frequency, duration). Each request gives one
// result on the output channel (out_valid_o/out_stall_i, out_data_o), in the
// cycle after it is accepted, from an output register.
// Ticks and refused or rest loads do not hold the input off. A load with
// a non-zero frequency and duration holds in_stall_o high while the bit-serial
// divider runs its 24 steps (one quotient bit per step of the 24-bit tone
// clock) and while the period registers are written.
// When the receiver stalls, the result waits in the output register and the
// next request is held off; nothing is lost or repeated.
// Configuration (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready; write only while the block is idle. Indexes: 0 tone clock in Hz,
// 1 ticks per millisecond, 2 gap in ms, 3 output mode (0 square, 1 sine).
// Reset: registers return to 1 MHz, 1000 ticks per ms, 25 ms gap, square wave
// mode; the player is idle and all timers clear.
// Depends on ntg_pkg, ntg_ctrl, ntg_datapath and the assertion macro header.
`include "note_tone_generator_top_macros.svh"

module note_tone_generator_top import ntg_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  out_item_t  result;
  out_item_t  out_data_q;
  logic       out_valid_q;
  logic       in_fire;

  // Hold requests off while the divider runs or the result register is stuck.
  assign in_stall_o = ctrl_cmd.hold | (out_valid_q & out_stall_i);
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_clock_hz <= TONE_CLOCK_RST;
      cfg_q.ticks_per_ms  <= TICKS_PER_MS_RST;
      cfg_q.gap_ms        <= GAP_MS_RST;
      cfg_q.output_mode   <= MODE_PWM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TONE_CLOCK:   cfg_q.tone_clock_hz <= cfg_data_i[CLK_W-1:0];
        REG_TICKS_PER_MS: cfg_q.ticks_per_ms  <= cfg_data_i[TPM_W-1:0];
        REG_GAP_MS:       cfg_q.gap_ms        <= cfg_data_i[GAP_W-1:0];
        REG_OUTPUT_MODE:  cfg_q.output_mode   <= cfg_data_i[0];
        default:          cfg_q               <= cfg_q;
      endcase
    end
  end

  ntg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_take_i (in_fire),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  ntg_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_take_i (in_fire),
    .item_i      (in_data_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .result_o    (result)
  );

  // Output register: load on accept, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Every accepted request leaves a result behind.
  `NTG_ASSERT_NEXT(a_result_follows, in_fire, out_valid_o, "accepted request gave no result")
  // A load that starts the divider blocks the next request.
  `NTG_ASSERT_NEXT(a_div_blocks, in_fire && dp_status.div_req, in_stall_o, "divider not holding input")
  // Square wave and sine output never drive at the same time.
  `NTG_ASSERT_NOW(a_one_output, out_valid_o && out_data_o.dac_sample != '0, !out_data_o.pwm_level, "pwm and sample both active")
  // A taken note either plays or ends the song.
  `NTG_ASSERT_NOW(a_accept_state, out_valid_o && out_data_o.accepted, out_data_o.busy_res || out_data_o.song_end, "accepted note neither busy nor song end")

endmodule
